/* src/ifpe_pkg.sv */
// Shared types and constants of the infrared frame pulse encoder.
`timescale 1ns / 1ps
`default_nettype none
package ifpe_pkg;

	localparam int MESSAGE_BYTES = 13;
	localparam int POS_W         = $clog2(MESSAGE_BYTES);
	localparam int DUR_W         = 16;
	localparam int BYTE_W        = 8;
	localparam int BIT_IDX_W     = $clog2(BYTE_W);
	localparam int CFG_IDX_W     = 3;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MESSAGE_BYTES - 1);

	typedef logic [DUR_W-1:0] dur_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER_MARK  = 3'd0,
		CFG_HEADER_SPACE = 3'd1,
		CFG_BIT_MARK     = 3'd2,
		CFG_ONE_SPACE    = 3'd3,
		CFG_ZERO_SPACE   = 3'd4,
		CFG_GAP_SPACE    = 3'd5
	} cfg_idx_t;

	localparam dur_t RST_HEADER_MARK  = 16'd8968;
	localparam dur_t RST_HEADER_SPACE = 16'd4425;
	localparam dur_t RST_BIT_MARK     = 16'd600;
	localparam dur_t RST_ONE_SPACE    = 16'd1650;
	localparam dur_t RST_ZERO_SPACE   = 16'd500;
	localparam dur_t RST_GAP_SPACE    = 16'd8968;

	typedef struct packed {
		dur_t lead_mark;
		dur_t lead_space;
		dur_t data_mark;
		dur_t high_space;
		dur_t low_space;
		dur_t tail_space;
	} timing_t;

	// One queued byte job: which framing pairs surround the eight bit pairs.
	typedef struct packed {
		logic              header;
		logic              trailer;
		logic [BYTE_W-1:0] data;
	} desc_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BITS,
		PH_TRAILER
	} phase_t;

endpackage
`default_nettype wire

/* src/ifpe_if.sv */
// Handshake channel interfaces for bytes in, pulse pairs out and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface ifpe_byte_if;
	logic                            valid;
	logic                            ready;
	logic [ifpe_pkg::BYTE_W-1:0]     data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface ifpe_pair_if;
	logic            valid;
	logic            ready;
	ifpe_pkg::dur_t  mark_us;
	ifpe_pkg::dur_t  space_us;
	logic            frame_end;
	logic            last_of_run;

	modport source (output valid, output mark_us, output space_us, output frame_end,
		output last_of_run, input ready);
	modport sink   (input valid, input mark_us, input space_us, input frame_end,
		input last_of_run, output ready);
endinterface

interface ifpe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ifpe_pkg::CFG_IDX_W-1:0]   reg_index;
	ifpe_pkg::dur_t                   wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

/* src/ifpe_cfg.sv */
// Timing register file written through the configuration channel.
`timescale 1ns / 1ps
`default_nettype none
module ifpe_cfg (
	input  wire              clk,
	input  wire              arst_n,
	ifpe_cfg_if.sink         cfg,
	output ifpe_pkg::timing_t timing
);

	ifpe_pkg::timing_t timing_q;
	logic              wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign timing    = timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.lead_mark  <= ifpe_pkg::RST_HEADER_MARK;
			timing_q.lead_space <= ifpe_pkg::RST_HEADER_SPACE;
			timing_q.data_mark  <= ifpe_pkg::RST_BIT_MARK;
			timing_q.high_space <= ifpe_pkg::RST_ONE_SPACE;
			timing_q.low_space  <= ifpe_pkg::RST_ZERO_SPACE;
			timing_q.tail_space <= ifpe_pkg::RST_GAP_SPACE;
		end else if (wr) begin
			// Indexes past the last register are dropped.
			case (ifpe_pkg::cfg_idx_t'(cfg.reg_index))
				ifpe_pkg::CFG_HEADER_MARK:  timing_q.lead_mark  <= cfg.wdata;
				ifpe_pkg::CFG_HEADER_SPACE: timing_q.lead_space <= cfg.wdata;
				ifpe_pkg::CFG_BIT_MARK:     timing_q.data_mark  <= cfg.wdata;
				ifpe_pkg::CFG_ONE_SPACE:    timing_q.high_space <= cfg.wdata;
				ifpe_pkg::CFG_ZERO_SPACE:   timing_q.low_space  <= cfg.wdata;
				ifpe_pkg::CFG_GAP_SPACE:    timing_q.tail_space <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/ifpe_front.sv */
// Front end: accepts frame bytes, tracks frame position and checksum, issues byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module ifpe_front (
	input  wire              clk,
	input  wire              arst_n,
	ifpe_byte_if.sink        byte_in,
	input  wire              q_full,
	output logic             q_push,
	output ifpe_pkg::desc_t  q_desc
);

	logic [ifpe_pkg::POS_W-1:0]  pos_q;
	logic [ifpe_pkg::BYTE_W-1:0] sum_q;
	logic                        last_byte;

	assign byte_in.ready = !q_full;
	assign q_push        = byte_in.valid && byte_in.ready;
	assign last_byte     = (pos_q == ifpe_pkg::LAST_POS);

	// The final byte of a frame carries the running sum instead of its own value.
	assign q_desc.header  = (pos_q == '0);
	assign q_desc.trailer = last_byte;
	assign q_desc.data    = last_byte ? sum_q : byte_in.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (q_push) begin
			if (last_byte) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_q + byte_in.data_byte;
			end
		end
	end

endmodule
`default_nettype wire

/* src/ifpe_fifo.sv */
// Two-entry queue of byte jobs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ifpe_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  ifpe_pkg::desc_t  push_desc,
	output logic             full,
	input  wire              pop,
	output logic             not_empty,
	output ifpe_pkg::desc_t  head_desc
);

	ifpe_pkg::desc_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head_desc = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/ifpe_back.sv */
// Back end: byte jobs to mark/space pairs, one pair per cycle if unstalled.
`timescale 1ns / 1ps
`default_nettype none
module ifpe_back (
	input  wire               clk,
	input  wire               arst_n,
	input  ifpe_pkg::timing_t timing,
	input  wire               q_not_empty,
	input  ifpe_pkg::desc_t   q_desc,
	output logic              q_pop,
	ifpe_pair_if.source       pair_out
);

	logic                           busy_q, busy_d;
	ifpe_pkg::desc_t                desc_q;
	ifpe_pkg::phase_t               phase_q, phase_d;
	logic [ifpe_pkg::BIT_IDX_W-1:0] bit_q, bit_d;

	logic                           out_valid_q;
	ifpe_pkg::dur_t                 mark_q, space_q;
	logic                           frame_end_q, last_of_run_q;

	ifpe_pkg::dur_t                 pair_mark, pair_space;
	logic                           pair_end, pair_last;
	logic                           advance, emit, load;

	// The output register may refill in the cycle its pair is taken.
	assign advance = !out_valid_q || pair_out.ready;
	assign emit    = busy_q && advance;
	// A new job starts in the same cycle as the final pair of the previous one.
	assign load    = advance && (!busy_q || pair_last) && q_not_empty;
	assign q_pop   = load;

	always_comb begin
		pair_mark  = timing.data_mark;
		pair_space = desc_q.data[bit_q] ? timing.high_space : timing.low_space;
		pair_end   = 1'b0;
		pair_last  = 1'b0;
		case (phase_q)
			ifpe_pkg::PH_HEADER: begin
				pair_mark  = timing.lead_mark;
				pair_space = timing.lead_space;
			end
			ifpe_pkg::PH_BITS: begin
				pair_last = (&bit_q) && !desc_q.trailer;
			end
			ifpe_pkg::PH_TRAILER: begin
				pair_space = timing.tail_space;
				pair_end   = 1'b1;
				pair_last  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		busy_d  = busy_q;
		if (emit) begin
			case (phase_q)
				ifpe_pkg::PH_HEADER: begin
					phase_d = ifpe_pkg::PH_BITS;
				end
				ifpe_pkg::PH_BITS: begin
					bit_d = bit_q + 1'b1;
					if (&bit_q) begin
						if (desc_q.trailer) begin
							phase_d = ifpe_pkg::PH_TRAILER;
						end else begin
							busy_d = 1'b0;
						end
					end
				end
				default: begin
					busy_d = 1'b0;
				end
			endcase
		end
		if (load) begin
			busy_d  = 1'b1;
			phase_d = q_desc.header ? ifpe_pkg::PH_HEADER : ifpe_pkg::PH_BITS;
			bit_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= ifpe_pkg::PH_HEADER;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= q_desc;
		end
		if (emit) begin
			mark_q        <= pair_mark;
			space_q       <= pair_space;
			frame_end_q   <= pair_end;
			last_of_run_q <= pair_last;
		end
	end

	assign pair_out.valid       = out_valid_q;
	assign pair_out.mark_us     = mark_q;
	assign pair_out.space_us    = space_q;
	assign pair_out.frame_end   = frame_end_q;
	assign pair_out.last_of_run = last_of_run_q;

endmodule
`default_nettype wire

/* src/ir_frame_pulse_encoder.sv */
// Top level of the infrared frame pulse encoder.
`timescale 1ns / 1ps
`default_nettype none
// Takes frame bytes on byte_in and emits pulse-distance mark/space pairs on pair_out,
// one pair per clock while the sink is ready: eight bit pairs per byte, LSB first,
// plus a header pair before the first byte of a frame and a trailer pair (frame_end)
// after the last, whose value is replaced by the 8-bit sum of the earlier bytes.
// The pair sequencer in the back end produces these pairs in order; a two-entry
// job queue in front of it lets bytes be taken while earlier ones are
// still being sent. last_of_run marks the final pair of each byte. Timing registers
// are written on cfg (index 0..5, other indexes ignored) and should only be
// changed while no pairs are pending.
module ir_frame_pulse_encoder (
	input  wire          clk,
	input  wire          arst_n,
	ifpe_byte_if.sink    byte_in,
	ifpe_pair_if.source  pair_out,
	ifpe_cfg_if.sink     cfg
);

	ifpe_pkg::timing_t timing;
	ifpe_pkg::desc_t   push_desc;
	ifpe_pkg::desc_t   head_desc;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_not_empty;

	ifpe_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.timing (timing)
	);

	ifpe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_desc  (push_desc)
	);

	ifpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_desc (head_desc)
	);

	ifpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.timing      (timing),
		.q_not_empty (q_not_empty),
		.q_desc      (head_desc),
		.q_pop       (q_pop),
		.pair_out    (pair_out)
	);

endmodule
`default_nettype wire
